/* src/point_marker_mesh_expander_macros.svh */
// Assertion macros for the point marker mesh expander
`ifndef POINT_MARKER_MESH_EXPANDER_MACROS_SVH
`define POINT_MARKER_MESH_EXPANDER_MACROS_SVH

// same-cycle implication
`define PMME_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("point marker expander: same-cycle check failed");

// next-cycle implication
`define PMME_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("point marker expander: next-cycle check failed");

`endif

/* src/pmme_pkg.sv */
// Shared constants, codes and tables for the point marker mesh expander
`timescale 1ns / 1ps
`default_nettype none
package pmme_pkg;
	localparam int MaxSegmentsDef = 62;
	localparam int CordicStepsDef = 16;
	localparam logic signed [33:0] CordicStart = 34'sd652032874;

	localparam logic [2:0] SHAPE_DOT     = 3'd0;
	localparam logic [2:0] SHAPE_CIRCLE  = 3'd1;
	localparam logic [2:0] SHAPE_SQUARE  = 3'd2;
	localparam logic [2:0] SHAPE_TRI     = 3'd3;
	localparam logic [2:0] SHAPE_DIAMOND = 3'd4;
	localparam logic [2:0] SHAPE_CROSS   = 3'd5;
	localparam logic [2:0] SHAPE_STAR    = 3'd6;
	localparam logic [2:0] SHAPE_CIRC_B  = 3'd7;

	localparam logic [1:0] REG_SHAPE = 2'd0;
	localparam logic [1:0] REG_SIZE  = 2'd1;
	localparam logic [1:0] REG_SEGS  = 2'd2;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] tri_angle(input logic [1:0] i);
		logic [31:0] v;
		unique case (i)
			2'd0: v = 32'hC0000000;
			2'd1: v = 32'h15555555;
			2'd2: v = 32'h6AAAAAAA;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] star_angle(input logic [3:0] i);
		logic [31:0] v;
		unique case (i)
			4'd0: v = 32'hC0000000;
			4'd1: v = 32'hD9999999;
			4'd2: v = 32'hF3333333;
			4'd3: v = 32'h0CCCCCCC;
			4'd4: v = 32'h26666666;
			4'd5: v = 32'h40000000;
			4'd6: v = 32'h59999999;
			4'd7: v = 32'h73333333;
			4'd8: v = 32'h8CCCCCCC;
			4'd9: v = 32'hA6666666;
			default: v = 32'h0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

/* src/pmme_div.sv */
// Shared divider: shift-subtract by the segment count, shift-add reciprocal by ten
`timescale 1ns / 1ps
`default_nettype none
module pmme_div import pmme_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        by_ten,
	input  wire logic [33:0] dividend,
	input  wire logic [5:0]  divisor,
	output logic             done,
	output logic [33:0]      quotient,
	output logic [5:0]       remainder
);
	logic [33:0] quo_q;
	logic [33:0] num_q;
	logic [5:0]  rem_q;
	logic [5:0]  den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        ten_q;
	logic [6:0]  trial;
	logic [6:0]  diff;
	logic        ge;

	assign trial = {rem_q, quo_q[33]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ten_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ten_q  <= by_ten;
				cnt_q  <= by_ten ? 6'd8 : 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q && ten_q) begin
			unique case (cnt_q)
				6'd8: quo_q <= (num_q >> 1) + (num_q >> 2);
				6'd7: quo_q <= quo_q + (quo_q >> 4);
				6'd6: quo_q <= quo_q + (quo_q >> 8);
				6'd5: quo_q <= quo_q + (quo_q >> 16);
				6'd4: quo_q <= quo_q + (quo_q >> 32);
				6'd3: quo_q <= quo_q >> 3;
				6'd2: num_q <= num_q - {quo_q[30:0], 3'b000} - {quo_q[32:0], 1'b0};
				default: quo_q <= quo_q + {33'd0, num_q > 34'd9};
			endcase
		end else if (busy_q) begin
			quo_q <= {quo_q[32:0], ge};
			rem_q <= ge ? diff[5:0] : trial[5:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

/* src/pmme_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per cycle, quadrant fold at the output
`timescale 1ns / 1ps
`default_nettype none
module pmme_cordic import pmme_pkg::*; #(
	parameter int STEPS = CordicStepsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] angle,
	output logic             done,
	output logic signed [31:0] cos_out,
	output logic signed [31:0] sin_out
);
	localparam logic [4:0] LastStep = 5'(STEPS - 1);

	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] dx, dy, atn;
	logic [4:0] i_q;
	logic [1:0] quad_q;
	logic       busy_q;
	logic       done_q;

	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign atn = $signed({2'b00, atan_turn(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CordicStart;
			y_q    <= '0;
			z_q    <= $signed({4'b0000, angle[29:0]});
			quad_q <= angle[31:30];
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atn;
			end
		end
	end

	always_comb begin
		unique case (quad_q)
			2'd0: begin
				cos_out = x_q[31:0];
				sin_out = y_q[31:0];
			end
			2'd1: begin
				cos_out = -y_q[31:0];
				sin_out = x_q[31:0];
			end
			2'd2: begin
				cos_out = -x_q[31:0];
				sin_out = -y_q[31:0];
			end
			default: begin
				cos_out = y_q[31:0];
				sin_out = -x_q[31:0];
			end
		endcase
	end

	assign done = done_q;
endmodule
`default_nettype wire

/* src/point_marker_mesh_expander.sv */
// Top level: point to marker mesh expander with sequencer, divider and CORDIC
// Each accepted point yields one word per mesh vertex (1 to 64 words). The input is taken
// only in the idle cycle between points. A shared divider first runs for circle
// (angle step 2^32/n, shift-subtract) or for cross (thickness) and star (inner
// radius, shift-add division by ten). Each rim or star/triangle vertex then runs the
// CORDIC (one micro-rotation per cycle) and two products on one multiplier; fixed-offset
// vertices skip both; an output stall holds the vertex until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "point_marker_mesh_expander_macros.svh"
module point_marker_mesh_expander import pmme_pkg::*; #(
	parameter int MAX_SEGMENTS = MaxSegmentsDef,
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // pos_x, pos_y, pos_z
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [191:0]      m_tdata,   // vert_x, vert_y, vert_z, tri_a, tri_b, tri_c
	output logic              m_tuser,   // tri_valid
	output logic              m_tlast,   // last_of_point
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_VERT = 3'd2;
	localparam logic [2:0] S_CORD = 3'd3;
	localparam logic [2:0] S_MULX = 3'd4;
	localparam logic [2:0] S_MULY = 3'd5;
	localparam logic [2:0] S_MULD = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;
	localparam logic [5:0] MaxSeg = 6'(MAX_SEGMENTS);
	localparam logic signed [64:0] RoundHalf = 65'sd536870912;

	logic [2:0]  state_q;
	logic [2:0]  shape_q;
	logic [31:0] size_q;
	logic [5:0]  segs_q;
	logic [31:0] index_base_q;
	logic [31:0] px_q, py_q, pz_q;
	logic [6:0]  k_q;
	logic [31:0] t_q, inner_q, qstep_q, acc_q, r_q, ox_q, oy_q;
	logic [5:0]  rstep_q, racc_q;
	logic signed [64:0] prod_q;
	logic [31:0] vx_q, vy_q, vz_q, ta_q, tb_q, tc_q;
	logic        tv_q, last_q, m_tvalid_q;

	logic        cfg_wr, accept, emit_load, is_circle, is_last, polar;
	logic [31:0] h, r_sel, angle_sel, fox, foy;
	logic [5:0]  n_eff;
	logic [6:0]  nv_w, nt_w, la, lb, lc, ring;
	logic        div_start, div_by_ten, div_done, cor_start, cor_done;
	logic [33:0] div_dividend, div_quo;
	logic [5:0]  div_divisor, div_rem;
	logic signed [31:0] cos_v, sin_v;
	logic signed [64:0] rsum;
	logic [6:0]  racc_sum;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = s_tvalid && s_tready;
	assign s_tready = state_q == S_IDLE;

	always_comb begin
		unique case (paddr[3:2])
			REG_SHAPE: prdata = {29'd0, shape_q};
			REG_SIZE:  prdata = size_q;
			REG_SEGS:  prdata = {26'd0, segs_q};
			default:   prdata = '0;
		endcase
	end

	assign h = {1'b0, size_q[31:1]};
	assign is_circle = shape_q == SHAPE_CIRCLE || shape_q == SHAPE_CIRC_B;

	always_comb begin
		priority if (segs_q < 6'd3)
			n_eff = 6'd3;
		else if (segs_q > MaxSeg)
			n_eff = MaxSeg;
		else
			n_eff = segs_q;
	end

	always_comb begin
		unique case (shape_q)
			SHAPE_DOT:     begin nv_w = 7'd1;  nt_w = 7'd0; end
			SHAPE_SQUARE,
			SHAPE_DIAMOND: begin nv_w = 7'd4;  nt_w = 7'd2; end
			SHAPE_TRI:     begin nv_w = 7'd3;  nt_w = 7'd1; end
			SHAPE_CROSS:   begin nv_w = 7'd8;  nt_w = 7'd4; end
			SHAPE_STAR:    begin nv_w = 7'd11; nt_w = 7'd10; end
			default:       begin nv_w = {1'b0, n_eff} + 7'd2; nt_w = {1'b0, n_eff}; end
		endcase
	end

	assign is_last = k_q == nv_w - 7'd1;

	always_comb begin
		div_start    = 1'b0;
		div_by_ten   = 1'b1;
		div_divisor  = n_eff;
		div_dividend = {2'b00, size_q} + 34'd5;
		if (is_circle) begin
			div_dividend = 34'h1_0000_0000;
			div_by_ten   = 1'b0;
		end else if (shape_q == SHAPE_STAR) begin
			div_dividend = {h, 2'b00} + 34'd5;
		end
		if (accept && (is_circle || shape_q == SHAPE_CROSS || shape_q == SHAPE_STAR))
			div_start = 1'b1;
	end

	pmme_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .by_ten(div_by_ten),
		.dividend(div_dividend), .divisor(div_divisor), .done(div_done),
		.quotient(div_quo), .remainder(div_rem)
	);

	always_comb begin
		polar     = 1'b0;
		angle_sel = acc_q;
		r_sel     = h;
		unique case (shape_q)
			SHAPE_TRI: begin
				polar     = 1'b1;
				angle_sel = tri_angle(k_q[1:0]);
			end
			SHAPE_STAR: begin
				polar     = k_q != 7'd0;
				angle_sel = star_angle(4'(k_q - 7'd1));
				r_sel     = k_q[0] ? h : inner_q;
			end
			SHAPE_CIRCLE, SHAPE_CIRC_B: polar = k_q != 7'd0;
			default: polar = 1'b0;
		endcase
	end

	assign cor_start = state_q == S_VERT && polar;

	pmme_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(angle_sel),
		.done(cor_done), .cos_out(cos_v), .sin_out(sin_v)
	);

	always_comb begin
		fox = '0;
		foy = '0;
		unique case (shape_q)
			SHAPE_SQUARE: begin
				fox = (k_q[1:0] == 2'd1 || k_q[1:0] == 2'd2) ? h : -h;
				foy = k_q[1] ? h : -h;
			end
			SHAPE_DIAMOND: begin
				unique case (k_q[1:0])
					2'd0: begin fox = '0; foy = h;  end
					2'd1: begin fox = h;  foy = '0; end
					2'd2: begin fox = '0; foy = -h; end
					default: begin fox = -h; foy = '0; end
				endcase
			end
			SHAPE_CROSS: begin
				unique case (k_q[2:0])
					3'd0: begin fox = -t_q; foy = h;    end
					3'd1: begin fox = t_q;  foy = h;    end
					3'd2: begin fox = t_q;  foy = -h;   end
					3'd3: begin fox = -t_q; foy = -h;   end
					3'd4: begin fox = -h;   foy = t_q;  end
					3'd5: begin fox = h;    foy = t_q;  end
					3'd6: begin fox = h;    foy = -t_q; end
					default: begin fox = -h; foy = -t_q; end
				endcase
			end
			default: begin fox = '0; foy = '0; end
		endcase
	end

	assign ring  = is_circle ? {1'b0, n_eff} : 7'd10;

	always_comb begin
		la = '0;
		lb = '0;
		lc = '0;
		unique case (shape_q)
			SHAPE_SQUARE, SHAPE_DIAMOND, SHAPE_CROSS: begin
				la = {k_q[5:1], 2'b00};
				lb = k_q[0] ? la + 7'd2 : la + 7'd1;
				lc = k_q[0] ? la + 7'd3 : la + 7'd2;
			end
			SHAPE_TRI: begin
				la = 7'd0; lb = 7'd1; lc = 7'd2;
			end
			SHAPE_STAR, SHAPE_CIRCLE, SHAPE_CIRC_B: begin
				la = 7'd0;
				lb = k_q + 7'd1;
				lc = (k_q + 7'd1 == ring) ? 7'd1 : k_q + 7'd2;
			end
			default: begin la = '0; lb = '0; lc = '0; end
		endcase
	end

	assign rsum      = prod_q + RoundHalf;
	assign emit_load = state_q == S_EMIT && (!m_tvalid_q || m_tready);
	assign racc_sum  = {1'b0, racc_q} + {1'b0, rstep_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			shape_q      <= SHAPE_CIRCLE;
			size_q       <= 32'd65536;
			segs_q       <= 6'd16;
			index_base_q <= '0;
			k_q          <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_SHAPE: shape_q <= pwdata[2:0];
					REG_SIZE:  size_q  <= pwdata;
					REG_SEGS:  segs_q  <= pwdata[5:0];
					default: ;
				endcase
			end
			if (emit_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						state_q <= div_start ? S_DIV : S_VERT;
					end
				end
				S_DIV:  if (div_done) state_q <= S_VERT;
				S_VERT: state_q <= polar ? S_CORD : S_EMIT;
				S_CORD: if (cor_done) state_q <= S_MULX;
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_MULD;
				S_MULD: state_q <= S_EMIT;
				default: begin
					if (emit_load) begin
						k_q <= k_q + 7'd1;
						if (is_last) begin
							index_base_q <= index_base_q + {25'd0, nv_w};
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_VERT;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= s_tdata[31:0];
			py_q <= s_tdata[63:32];
			pz_q <= s_tdata[95:64];
		end
		if (state_q == S_DIV && div_done) begin
			qstep_q <= div_quo[31:0];
			rstep_q <= div_rem;
			acc_q   <= '0;
			racc_q  <= '0;
			t_q     <= div_quo[31:0];
			inner_q <= div_quo[31:0];
		end
		if (state_q == S_VERT) begin
			r_q <= r_sel;
			if (!polar) begin
				ox_q <= fox;
				oy_q <= foy;
			end
		end
		if (state_q == S_MULX)
			prod_q <= $signed({1'b0, r_q}) * cos_v;
		if (state_q == S_MULY) begin
			ox_q   <= rsum[61:30];
			prod_q <= $signed({1'b0, r_q}) * sin_v;
		end
		if (state_q == S_MULD)
			oy_q <= rsum[61:30];
		if (emit_load) begin
			vx_q   <= px_q + ox_q;
			vy_q   <= py_q + oy_q;
			vz_q   <= pz_q;
			tv_q   <= k_q < nt_w;
			ta_q   <= (k_q < nt_w) ? index_base_q + {25'd0, la} : '0;
			tb_q   <= (k_q < nt_w) ? index_base_q + {25'd0, lb} : '0;
			tc_q   <= (k_q < nt_w) ? index_base_q + {25'd0, lc} : '0;
			last_q <= is_last;
			if (is_circle && k_q != 7'd0) begin
				if (racc_sum >= {1'b0, n_eff}) begin
					racc_q <= 6'(racc_sum - {1'b0, n_eff});
					acc_q  <= acc_q + qstep_q + 32'd1;
				end else begin
					racc_q <= racc_sum[5:0];
					acc_q  <= acc_q + qstep_q;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {tc_q, tb_q, ta_q, vz_q, vy_q, vx_q};
	assign m_tuser  = tv_q;
	assign m_tlast  = last_q;

	`PMME_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, state_q != S_IDLE)
	`PMME_ASSERT_IMP(a_vertex_in_mesh, clk, arst_n, state_q == S_EMIT, k_q < nv_w)
	`PMME_ASSERT_NEXT(a_last_ends_point, clk, arst_n, emit_load && is_last,
		state_q == S_IDLE && m_tlast && m_tvalid)
	`PMME_ASSERT_NEXT(a_tri_only_in_range, clk, arst_n, emit_load && (k_q >= nt_w), !m_tuser)
endmodule
`default_nettype wire
